FILE: rtl/sssp_pkg.sv
// Shared types and constants for the shortest path block.
// No dependencies.
`default_nettype none
package sssp_pkg;
  localparam int unsigned NODE_W = 6;
  localparam int unsigned WT_W   = 16;
  localparam int unsigned DIST_W = 22;
  localparam int unsigned CNT_W  = 7;

  localparam logic CMD_ADD = 1'b0;
  localparam logic CMD_RUN = 1'b1;

  typedef struct packed {
    logic [NODE_W-1:0] src;
    logic [NODE_W-1:0] dst;
    logic [WT_W-1:0]   wt;
  } edge_t;
endpackage
`default_nettype wire

FILE: rtl/single_source_shortest_path.sv
// Top level: command decode, Dijkstra sequencer, result output register.
// Depends on sssp_pkg, sssp_edge_mem, sssp_dist_mem.
//
//  channel | valid / ready    | payload
//  in      | in_valid_i/_o    | cmd, from_node, to_node, edge_weight, both_ways
//  out     | out_valid_o/_i   | node_index, distance, reachable, last, edge_overflow
//  cfg     | cfg_valid_i/_o   | cfg_data_i (node_count)
//
// Add edge: one edge store write, or a second write in S_REV with both_ways
// (one edge store write port). Run: accept, an init pass over the n nodes,
// then per settled node a scan of the nodes and an edge sweep of S_EDGE, S_ERD,
// S_RELAX per stored edge; a final scan finds nothing left. Then S_ORD, S_OUT
// per reported node. Each memory has a single read port; input and cfg ready only in idle.
// No clearing pass after reset; output stalls hold the output register.
`default_nettype none
module single_source_shortest_path #(
  parameter int unsigned NODES      = 32,
  parameter int unsigned EDGE_SLOTS = 256
) (
  input  wire  logic        clk_i,
  input  wire  logic        rst_ni,
  input  wire  logic        cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire  logic [6:0]  cfg_data_i,
  input  wire  logic        in_valid_i,
  output logic              in_ready_o,
  input  wire  logic        cmd_i,
  input  wire  logic [5:0]  from_node_i,
  input  wire  logic [5:0]  to_node_i,
  input  wire  logic [15:0] edge_weight_i,
  input  wire  logic        both_ways_i,
  output logic              out_valid_o,
  input  wire  logic        out_ready_i,
  output logic [5:0]        node_index_o,
  output logic [21:0]       distance_o,
  output logic              reachable_o,
  output logic              last_o,
  output logic              edge_overflow_o
);
  localparam int unsigned NA = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int unsigned EA = $clog2(EDGE_SLOTS);
  localparam int unsigned EC = $clog2(EDGE_SLOTS + 1);
  localparam int unsigned DW = sssp_pkg::DIST_W;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_REV   = 9'b000000010,
    S_INIT  = 9'b000000100,
    S_SCAN  = 9'b000001000,
    S_EDGE  = 9'b000010000,
    S_ERD   = 9'b000100000,
    S_RELAX = 9'b001000000,
    S_ORD   = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic [6:0] ncfg_q;
  logic [EC-1:0] etot_q;
  logic ovf_q;

  logic [6:0] n_q;
  logic [NA:0] idx_q;
  logic [NA:0] best_q;
  logic [DW-1:0] bestd_q;
  logic [EC-1:0] eidx_q;
  sssp_pkg::edge_t rev_q, cur_q;

  // edge memory
  logic e_we;
  logic [EA-1:0] e_wa;
  sssp_pkg::edge_t e_wd, e_rd;
  sssp_edge_mem #(.DEPTH(EDGE_SLOTS), .AW(EA)) u_edge (
    .clk_i, .we_i(e_we), .waddr_i(e_wa), .wdata_i(e_wd),
    .raddr_i(eidx_q[EA-1:0]), .rdata_o(e_rd));

  // distance memory: bit DW+1 reached, bit DW settled
  logic d_we;
  logic [NA-1:0] d_wa, d_ra;
  logic [DW+1:0] d_wd, d_rd;
  sssp_dist_mem #(.DEPTH(NODES), .AW(NA)) u_dist (
    .clk_i, .we_i(d_we), .waddr_i(d_wa), .wdata_i(d_wd),
    .raddr_i(d_ra), .rdata_o(d_rd));

  logic [6:0] n_eff;
  always_comb begin
    if (ncfg_q == '0) n_eff = 7'd1;
    else if (ncfg_q > 7'(NODES)) n_eff = 7'(NODES);
    else n_eff = ncfg_q;
  end

  logic in_acc, out_free, full;
  logic [DW:0] cand;
  assign out_free   = !out_valid_o || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);
  assign cfg_ready_o = (state_q == S_IDLE);
  assign full       = (etot_q >= EC'(EDGE_SLOTS));
  assign cand       = {1'b0, bestd_q} + (DW+1)'(cur_q.wt);

  // read address of distance memory
  always_comb begin
    d_ra = idx_q[NA-1:0];
    if (state_q == S_ERD) d_ra = e_rd.dst[NA-1:0];
  end

  always_comb begin
    state_d = state_q;
    e_we = 1'b0; e_wa = etot_q[EA-1:0];
    e_wd = '{src: from_node_i, dst: to_node_i, wt: edge_weight_i};
    d_we = 1'b0; d_wa = idx_q[NA-1:0]; d_wd = '0;
    case (state_q)
      S_IDLE: if (in_acc) begin
        if (cmd_i == sssp_pkg::CMD_ADD) begin
          e_we = !full;
          if (both_ways_i) state_d = S_REV;
        end else state_d = S_INIT;
      end
      S_REV: begin
        e_we = !full; e_wd = rev_q; state_d = S_IDLE;
      end
      S_INIT: begin
        d_we = 1'b1;
        d_wd = {(idx_q == {1'b0, rev_q.src[NA-1:0]}) && (7'(rev_q.src) < n_q), 1'b0, {DW{1'b0}}};
        if (idx_q == (NA+1)'(n_q - 7'd1)) state_d = S_SCAN;
      end
      S_SCAN: begin
        // d_rd holds the entry of idx_q - 1 (registered read); evaluation happens on d_rd
        if (idx_q == (NA+1)'(n_q) + 1'b1) begin
          if (best_q == (NA+1)'(n_q)) state_d = S_ORD;
          else begin
            state_d = S_EDGE;
            d_we = 1'b1; d_wa = best_q[NA-1:0];
            d_wd = {1'b1, 1'b1, bestd_q};
          end
        end
      end
      S_EDGE: begin
        if (eidx_q >= etot_q) state_d = S_SCAN;
        else state_d = S_ERD;
      end
      S_ERD: state_d = S_RELAX;
      S_RELAX: begin
        if (7'(cur_q.src) == 7'(best_q) && 7'(cur_q.dst) < n_q &&
            7'(cur_q.src) < n_q &&
            (!d_rd[DW+1] || cand[DW-1:0] < d_rd[DW-1:0])) begin
          d_we = 1'b1; d_wa = cur_q.dst[NA-1:0];
          d_wd = {1'b1, d_rd[DW], cand[DW-1:0]};
        end
        state_d = S_EDGE;
      end
      S_ORD: state_d = S_OUT;
      S_OUT: if (out_free) begin
        if (idx_q == (NA+1)'(n_q - 7'd1)) state_d = S_IDLE;
        else state_d = S_ORD;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // cur_q captured from e_rd in S_ERD; relax in S_RELAX reads d_rd of dst
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; ncfg_q <= 7'd32; etot_q <= '0; ovf_q <= 1'b0;
      out_valid_o <= 1'b0; idx_q <= '0; best_q <= '0; eidx_q <= '0; n_q <= 7'd1;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) ncfg_q <= cfg_data_i;
      if (state_q == S_OUT && out_free) out_valid_o <= 1'b1;
      else if (out_ready_i) out_valid_o <= 1'b0;
      if (e_we) etot_q <= etot_q + 1'b1;
      if ((state_q == S_IDLE && in_acc && cmd_i == sssp_pkg::CMD_ADD && full) ||
          (state_q == S_REV && full)) ovf_q <= 1'b1;
      case (state_q)
        S_IDLE: begin
          idx_q <= '0; n_q <= n_eff;
        end
        S_INIT: begin
          if (state_d == S_SCAN) begin
            idx_q <= '0; best_q <= (NA+1)'(n_q);
          end else idx_q <= idx_q + 1'b1;
        end
        S_SCAN: begin
          if (idx_q != '0 && idx_q <= (NA+1)'(n_q)) begin
            if (d_rd[DW+1] && !d_rd[DW] &&
                (best_q == (NA+1)'(n_q) || d_rd[DW-1:0] < bestd_q)) begin
              best_q <= idx_q - 1'b1; bestd_q <= d_rd[DW-1:0];
            end
          end
          if (state_d == S_ORD) idx_q <= '0;
          else idx_q <= idx_q + 1'b1;
          if (state_d == S_EDGE) eidx_q <= '0;
        end
        S_EDGE: if (state_d == S_SCAN) begin
          idx_q <= '0; best_q <= (NA+1)'(n_q);
        end
        S_RELAX: eidx_q <= eidx_q + 1'b1;
        S_OUT: if (out_free) idx_q <= idx_q + 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) rev_q <= '{src: (cmd_i == sssp_pkg::CMD_RUN) ? from_node_i : to_node_i,
                           dst: from_node_i, wt: edge_weight_i};
    if (state_q == S_ERD) cur_q <= e_rd;
    if (state_q == S_OUT && out_free) begin
      node_index_o    <= 6'(idx_q);
      reachable_o     <= d_rd[DW+1];
      distance_o      <= d_rd[DW+1] ? d_rd[DW-1:0] : '0;
      last_o          <= (idx_q == (NA+1)'(n_q - 7'd1));
      edge_overflow_o <= ovf_q;
    end
  end

  a_idle_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == S_IDLE) else $error("ready outside idle");
  a_etot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    etot_q <= EC'(EDGE_SLOTS)) else $error("edge count overrun");
  a_full_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (e_we && full) |-> 1'b0) else $error("write to full store");
endmodule
`default_nettype wire

FILE: rtl/sssp_edge_mem.sv
// Edge store: one write port, one registered read port.
// Depends on sssp_pkg.
`default_nettype none
module sssp_edge_mem #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  wire  logic                clk_i,
  input  wire  logic                we_i,
  input  wire  logic [AW-1:0]       waddr_i,
  input  wire  sssp_pkg::edge_t     wdata_i,
  input  wire  logic [AW-1:0]       raddr_i,
  output sssp_pkg::edge_t           rdata_o
);
  sssp_pkg::edge_t mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

FILE: rtl/sssp_dist_mem.sv
// Per-node distance memory {reached, settled, distance}; registered read.
// Depends on sssp_pkg.
`default_nettype none
module sssp_dist_mem #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = 5
) (
  input  wire  logic                              clk_i,
  input  wire  logic                              we_i,
  input  wire  logic [AW-1:0]                     waddr_i,
  input  wire  logic [sssp_pkg::DIST_W+1:0]       wdata_i,
  input  wire  logic [AW-1:0]                     raddr_i,
  output logic [sssp_pkg::DIST_W+1:0]             rdata_o
);
  logic [sssp_pkg::DIST_W+1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire
